// ===== design/crc_pkg.sv =====
// Shared codes and default sizes for the channel rendezvous coordinator.
package crc_pkg;

  localparam int CMD_BITS  = 3;
  localparam int SLOT_BITS = 8;
  localparam int ERR_BITS  = 2;
  localparam int PH_BITS   = 3;

  localparam int SLOTS_DEFAULT     = 256;
  localparam int WORKERS_DEFAULT   = 16;
  localparam int DATA_BITS_DEFAULT = 64;

  localparam logic [CMD_BITS-1:0] CMD_INPUT    = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_OUTPUT   = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_ENABLE   = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_DISABLE  = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_RESOLVED = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_DONE     = 3'd5;

  localparam logic [PH_BITS-1:0] PH_NORMAL    = 3'd0;
  localparam logic [PH_BITS-1:0] PH_IN_WAIT   = 3'd1;
  localparam logic [PH_BITS-1:0] PH_OUT_WAIT  = 3'd2;
  localparam logic [PH_BITS-1:0] PH_ENABLED   = 3'd3;
  localparam logic [PH_BITS-1:0] PH_READY     = 3'd4;
  localparam logic [PH_BITS-1:0] PH_DONE_WAIT = 3'd5;

  localparam logic [ERR_BITS-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_UNHANDLED = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_FROM_OWNER = 2'd2;

endpackage

// ===== design/crc_result_queue.sv =====
// Four-entry result queue taking up to two beats per cycle and giving one.
module crc_result_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [W-1:0] push_first,
  input  logic [W-1:0] push_second,
  input  logic [1:0]   push_count,
  output logic         room,
  output logic [W-1:0] pop_data,
  output logic         pop_valid,
  input  logic         pop_ready
);
  import crc_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  logic [W-1:0]  entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign room      = (count <= (PW + 1)'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push_first;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + PW'(1)] <= push_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (PW + 1)'(push_count) - (PW + 1)'(pop);
    end
  end

endmodule

// ===== design/channel_rendezvous_coordinator_top.sv =====
// Top level of the channel rendezvous coordinator: slot table, event logic and result queue.
//
// Input channel (in_valid/in_ready) carries one channel event per beat: command, sender,
// channel_slot, owner_id and payload. Output channel (out_valid/out_ready) carries result
// beats: dest_worker, msg_kind, slot_out, data_out, error_code and last. An event gives
// zero, one or two beats; last marks its final beat, and an event that fails gives one
// error beat.
// An accepted event and its slot read are registered in the event stage; its result beats
// then go into the result queue, which drives the output channel. Throughput: one event per
// cycle while the output keeps up; with two beats per event the single output beat per
// cycle sets the pace. The slot table is two memories (phase data, held data), each with one
// read and one write port; a one-entry forward path for each covers an event that hits the
// slot the previous event has just written. Reset: the table is swept back to the normal
// phase one slot per cycle, in_ready low until the sweep ends. Held data is not cleared.
// Receiver stall: results gather in a four-entry queue; once it cannot take two more beats
// the event stage holds and in_ready drops, so no beat is lost.
module channel_rendezvous_coordinator_top #(
  parameter int SLOTS     = crc_pkg::SLOTS_DEFAULT,
  parameter int WORKERS   = crc_pkg::WORKERS_DEFAULT,
  parameter int DATA_BITS = crc_pkg::DATA_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [crc_pkg::CMD_BITS-1:0]   command,
  input  logic [$clog2(WORKERS)-1:0]     sender,
  input  logic [crc_pkg::SLOT_BITS-1:0]  channel_slot,
  input  logic [$clog2(WORKERS)-1:0]     owner_id,
  input  logic [DATA_BITS-1:0]           payload,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [$clog2(WORKERS)-1:0]     dest_worker,
  output logic [crc_pkg::CMD_BITS-1:0]   msg_kind,
  output logic [crc_pkg::SLOT_BITS-1:0]  slot_out,
  output logic [DATA_BITS-1:0]           data_out,
  output logic [crc_pkg::ERR_BITS-1:0]   error_code,
  output logic                           last
);
  import crc_pkg::*;

  localparam int WB        = $clog2(WORKERS);
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int SLOT_SPAN = 2 ** SLOT_BITS;

  typedef struct packed {
    logic [PH_BITS-1:0] phase;
    logic [WB-1:0]      reader;
    logic [WB-1:0]      writer;
    logic [WB-1:0]      enabler;
  } meta_t;

  typedef struct packed {
    logic [WB-1:0]        dest;
    logic [CMD_BITS-1:0]  kind;
    logic [SLOT_BITS-1:0] slot;
    logic [DATA_BITS-1:0] data;
    logic [ERR_BITS-1:0]  err;
    logic                 last;
  } result_t;

  localparam int RES_BITS = $bits(result_t);

  function automatic result_t make_result(logic [WB-1:0] dest, logic [CMD_BITS-1:0] kind,
                                          logic [SLOT_BITS-1:0] slot,
                                          logic [DATA_BITS-1:0] data,
                                          logic [ERR_BITS-1:0] err, logic fin);
    result_t r;
    r.dest = dest;
    r.kind = kind;
    r.slot = slot;
    r.data = data;
    r.err  = err;
    r.last = fin;
    return r;
  endfunction

  logic [IDX_W-1:0] slot_map [SLOT_SPAN];

  for (genvar g = 0; g < SLOT_SPAN; g++) begin : g_slot_map
    assign slot_map[g] = IDX_W'(g % SLOTS);
  end

  meta_t                meta_mem [SLOTS];
  logic [DATA_BITS-1:0] held_mem [SLOTS];

  logic             clearing;
  logic [IDX_W-1:0] clr_addr;

  logic                 s1_valid;
  logic [CMD_BITS-1:0]  s1_cmd;
  logic [WB-1:0]        s1_sender;
  logic [SLOT_BITS-1:0] s1_slot;
  logic [IDX_W-1:0]     s1_idx;
  logic [WB-1:0]        s1_owner;
  logic [DATA_BITS-1:0] s1_payload;
  meta_t                meta_rd;
  logic [DATA_BITS-1:0] held_rd;

  logic                 byp_valid;
  logic [IDX_W-1:0]     byp_idx;
  meta_t                byp_meta;
  logic                 held_byp_valid;
  logic [IDX_W-1:0]     held_byp_idx;
  logic [DATA_BITS-1:0] held_byp_data;

  meta_t                cur_meta;
  logic [DATA_BITS-1:0] cur_held;
  meta_t                meta_next;
  logic                 held_we;
  result_t              res_first;
  result_t              res_second;
  logic [1:0]           res_count;
  logic                 from_owner;
  logic                 accept;
  logic                 adv;
  logic                 q_room;
  result_t              q_out;

  assign adv      = s1_valid && q_room;
  assign in_ready = !clearing && (!s1_valid || adv);
  assign accept   = in_valid && in_ready;

  // sweep the table back to normal after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + IDX_W'(1);
      if (clr_addr == IDX_W'(SLOTS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      meta_mem[clr_addr] <= '0;
    end else if (adv) begin
      meta_mem[s1_idx] <= meta_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && held_we) begin
      held_mem[s1_idx] <= s1_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meta_rd <= meta_mem[slot_map[channel_slot]];
      held_rd <= held_mem[slot_map[channel_slot]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd     <= command;
      s1_sender  <= sender;
      s1_slot    <= channel_slot;
      s1_idx     <= slot_map[channel_slot];
      s1_owner   <= owner_id;
      s1_payload <= payload;
    end
  end

  // forward the last write to an event that read the same slot too early
  always_ff @(posedge clk) begin
    if (rst) begin
      byp_valid      <= 1'b0;
      held_byp_valid <= 1'b0;
    end else if (adv) begin
      byp_valid <= 1'b1;
      if (held_we) begin
        held_byp_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byp_idx  <= s1_idx;
      byp_meta <= meta_next;
      if (held_we) begin
        held_byp_idx  <= s1_idx;
        held_byp_data <= s1_payload;
      end
    end
  end

  assign cur_meta   = (byp_valid && byp_idx == s1_idx) ? byp_meta : meta_rd;
  assign cur_held   = (held_byp_valid && held_byp_idx == s1_idx) ? held_byp_data : held_rd;
  assign from_owner = (s1_sender == s1_owner);

  always_comb begin
    result_t err_unhandled;
    result_t err_owner;
    err_unhandled = make_result(s1_sender, s1_cmd, s1_slot, '0, ERR_UNHANDLED, 1'b1);
    err_owner     = make_result(s1_sender, s1_cmd, s1_slot, '0, ERR_FROM_OWNER, 1'b1);
    meta_next  = cur_meta;
    held_we    = 1'b0;
    res_first  = err_unhandled;
    res_second = err_unhandled;
    res_count  = 2'd1;
    case (s1_cmd)
      CMD_INPUT: begin
        if (cur_meta.phase == PH_NORMAL) begin
          if (from_owner) begin
            res_first = err_owner;
          end else begin
            meta_next.phase  = PH_IN_WAIT;
            meta_next.reader = s1_sender;
            res_first = make_result(s1_owner, CMD_INPUT, s1_slot, '0, ERR_NONE, 1'b1);
          end
        end else if (cur_meta.phase == PH_OUT_WAIT) begin
          meta_next.phase = PH_DONE_WAIT;
          res_first  = make_result(s1_sender, CMD_OUTPUT, s1_slot, cur_held, ERR_NONE, 1'b0);
          res_second = make_result(s1_owner, CMD_RESOLVED, s1_slot, '0, ERR_NONE, 1'b1);
          res_count  = 2'd2;
        end
      end
      CMD_OUTPUT: begin
        if (cur_meta.phase == PH_NORMAL) begin
          if (from_owner) begin
            res_first = err_owner;
          end else begin
            meta_next.phase  = PH_OUT_WAIT;
            meta_next.writer = s1_sender;
            held_we   = 1'b1;
            res_first = make_result(s1_owner, CMD_OUTPUT, s1_slot, s1_payload, ERR_NONE, 1'b1);
          end
        end else if (cur_meta.phase == PH_IN_WAIT) begin
          meta_next.phase  = PH_DONE_WAIT;
          meta_next.writer = s1_sender;
          held_we   = 1'b1;
          res_first = make_result(cur_meta.reader, CMD_OUTPUT, s1_slot, s1_payload, ERR_NONE,
                                  from_owner);
          res_second = make_result(s1_owner, CMD_RESOLVED, s1_slot, '0, ERR_NONE, 1'b1);
          res_count  = from_owner ? 2'd1 : 2'd2;
        end else if (cur_meta.phase == PH_ENABLED) begin
          meta_next.phase  = PH_READY;
          meta_next.writer = s1_sender;
          held_we   = 1'b1;
          res_first = make_result(cur_meta.enabler, CMD_OUTPUT, s1_slot, s1_payload, ERR_NONE,
                                  1'b1);
        end
      end
      CMD_ENABLE: begin
        if (cur_meta.phase == PH_NORMAL) begin
          if (from_owner) begin
            res_first = err_owner;
          end else begin
            meta_next.phase   = PH_ENABLED;
            meta_next.enabler = s1_sender;
            res_first = make_result(s1_owner, CMD_ENABLE, s1_slot, '0, ERR_NONE, 1'b1);
          end
        end else if (cur_meta.phase == PH_OUT_WAIT) begin
          if (from_owner) begin
            res_first = err_owner;
          end else begin
            meta_next.phase = PH_READY;
            res_first  = make_result(s1_sender, CMD_OUTPUT, s1_slot, cur_held, ERR_NONE, 1'b0);
            res_second = make_result(s1_owner, CMD_RESOLVED, s1_slot, '0, ERR_NONE, 1'b1);
            res_count  = 2'd2;
          end
        end
      end
      CMD_DISABLE: begin
        if (cur_meta.phase == PH_ENABLED || cur_meta.phase == PH_READY) begin
          if (from_owner) begin
            res_first = err_owner;
          end else begin
            meta_next.phase = (cur_meta.phase == PH_ENABLED) ? PH_NORMAL : PH_OUT_WAIT;
            res_first = make_result(s1_owner, CMD_DISABLE, s1_slot, '0, ERR_NONE, 1'b1);
          end
        end
      end
      CMD_RESOLVED: begin
        if (cur_meta.phase == PH_IN_WAIT || cur_meta.phase == PH_OUT_WAIT) begin
          meta_next.phase = PH_NORMAL;
          res_count = 2'd0;
        end
      end
      CMD_DONE: begin
        if (cur_meta.phase == PH_OUT_WAIT || cur_meta.phase == PH_DONE_WAIT) begin
          meta_next.phase = PH_NORMAL;
          res_first = make_result(cur_meta.writer, CMD_DONE, s1_slot, '0, ERR_NONE, 1'b1);
        end
      end
      default: begin
        res_count = 2'd1;
      end
    endcase
  end

  crc_result_queue #(
    .W(RES_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_first (res_first),
    .push_second(res_second),
    .push_count (adv ? res_count : 2'd0),
    .room       (q_room),
    .pop_data   (q_out),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready)
  );

  assign dest_worker = q_out.dest;
  assign msg_kind    = q_out.kind;
  assign slot_out    = q_out.slot;
  assign data_out    = q_out.data;
  assign error_code  = q_out.err;
  assign last        = q_out.last;

endmodule
